FILE: hw/rtl/bspl_pkg.sv
package bspl_pkg;

  localparam int SAMPLES_PER_SPAN = 5;
  localparam int SMP_W = (SAMPLES_PER_SPAN > 1) ? $clog2(SAMPLES_PER_SPAN) : 1;
  localparam int COORD_W = 16;
  localparam int WGT_W = 16;
  localparam int ACC_W = 35;
  localparam int NUM_CLASS = 16;
  localparam int CLS_W = 4;
  localparam int FRAC_SHIFT = 15;
  localparam longint WFULL = 12 * SAMPLES_PER_SPAN * SAMPLES_PER_SPAN * SAMPLES_PER_SPAN;

  typedef logic [3:0][WGT_W-1:0] wrow_t;
  typedef wrow_t [SAMPLES_PER_SPAN-1:0] wspan_t;
  typedef wspan_t [NUM_CLASS-1:0] wtab_t;

  typedef struct packed {
    logic en;
    logic load;
  } mac_ctl_t;

  // Knot value scaled by the sample count, for a curve whose last point index is m.
  function automatic longint knot_scaled(longint j, longint m);
    longint k;
    if (j <= 3) begin
      k = 0;
    end else if (j <= m) begin
      k = j - 3;
    end else begin
      k = m - 2;
    end
    return k * SAMPLES_PER_SPAN;
  endfunction

  // Knot differences are one, two or three spans wide.
  function automatic longint knot_div(longint x, longint d);
    longint r;
    case (d / SAMPLES_PER_SPAN)
      1: r = x / SAMPLES_PER_SPAN;
      2: r = x / (2 * SAMPLES_PER_SPAN);
      3: r = x / (3 * SAMPLES_PER_SPAN);
      default: r = 0;
    endcase
    return r;
  endfunction

  // Cox-de Boor weights for span i and sample s; entry 0 weighs the newest point.
  function automatic wrow_t span_w(longint i, longint s, longint m);
    longint nb [7];
    longint t;
    longint j;
    longint a;
    longint b;
    longint kj;
    longint kj1;
    longint kjp;
    longint d1;
    longint d2;
    longint lft;
    longint rgt;
    longint v;
    wrow_t w;
    t = SAMPLES_PER_SPAN * (i - 3) + s;
    for (int o = 0; o < 7; o++) begin
      j = i - 3 + o;
      a = knot_scaled(j, m);
      b = knot_scaled(j + 1, m);
      nb[o] = (a < b && a <= t && t < b) ? WFULL : 0;
    end
    for (int p = 2; p <= 4; p++) begin
      for (int o = 0; o <= 7 - p; o++) begin
        j = i - 3 + o;
        kj = knot_scaled(j, m);
        kj1 = knot_scaled(j + 1, m);
        kjp = knot_scaled(j + p, m);
        d1 = knot_scaled(j + p - 1, m) - kj;
        d2 = kjp - kj1;
        lft = 0;
        rgt = 0;
        if (d1 > 0) lft = knot_div((t - kj) * nb[o], d1);
        if (d2 > 0) rgt = knot_div((kjp - t) * nb[o + 1], d2);
        nb[o] = lft + rgt;
      end
    end
    for (int o = 0; o < 4; o++) begin
      v = nb[3 - o];
      if (v < 0) v = 0;
      w[o] = WGT_W'((v * 32768 + WFULL / 2) / WFULL);
    end
    return w;
  endfunction

  // Class index is {distance from the curve start, distance from the curve end}, each capped at 3.
  function automatic wtab_t build_wtab();
    wtab_t tab;
    longint i;
    longint m;
    for (int ca = 0; ca < 4; ca++) begin
      for (int cb = 0; cb < 4; cb++) begin
        for (int s = 0; s < SAMPLES_PER_SPAN; s++) begin
          i = 3 + ca;
          m = i + cb;
          tab[ca * 4 + cb][s] = span_w(i, s, m);
        end
      end
    end
    return tab;
  endfunction

  localparam wtab_t W_TAB = build_wtab();

endpackage

FILE: hw/rtl/cubic_bspline_curve_sampler.sv
// For a point that completes a span, each of its samples takes eight multiply-accumulates on
// the shared multiplier and one output load, and in_tready stays low until the last sample,
// and for the final point also the final point itself, is loaded; output stalls hold it low longer.
// The first sample goes from ST_MAC through ST_PUSH into the output register. One of the first
// three points of a curve is taken without leaving ST_IDLE, gives no result and leaves in_tready high.
// Reset clears the point window, the point index and the output valid flag; point_count is 4.
module cubic_bspline_curve_sampler import bspl_pkg::*; #(
  parameter int MAX_POINTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // coord_x [15:0], coord_y [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // curve_x [15:0], curve_y [31:16]
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // curve_done [0]
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = ($clog2(MAX_POINTS + 1) > 6) ? $clog2(MAX_POINTS + 1) : 6;
  localparam logic [SMP_W-1:0] SMP_LAST = SMP_W'(SAMPLES_PER_SPAN - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_PUSH = 4'b0100,
    ST_LAST = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]               tap_r;
  logic [SMP_W-1:0]         smp_r;
  logic [CLS_W-1:0]         cls_r;
  logic                     final_r;
  logic signed [COORD_W-1:0] cur_x_r, cur_y_r;
  logic signed [COORD_W-1:0] win_x_r [3];
  logic signed [COORD_W-1:0] win_y_r [3];
  logic signed [COORD_W-1:0] res_x_r;
  logic [IDX_W-1:0]         idx_r;
  logic [5:0]               cnt_r;
  logic                     out_valid_r;
  logic [31:0]              out_data_r;
  logic                     out_last_r;
  logic                     out_done_r;

  logic [CNT_W-1:0]         cnt_ext, n_eff, m_eff, idx_ext, gap;
  logic                     has_span, is_final;
  logic [1:0]               ca, cb;
  logic                     accept, out_free, commit;
  logic signed [COORD_W-1:0] new_x, new_y;
  logic signed [COORD_W-1:0] mac_coord, mac_res;
  logic [WGT_W-1:0]         mac_wgt;
  mac_ctl_t                 mac_ctl;

  assign cnt_ext = CNT_W'(cnt_r);
  assign idx_ext = CNT_W'(idx_r);

  always_comb begin
    if (cnt_ext < CNT_W'(4)) begin
      n_eff = CNT_W'(4);
    end else if (cnt_ext > CNT_W'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = cnt_ext;
    end
  end

  assign m_eff    = n_eff - CNT_W'(1);
  assign has_span = idx_ext >= CNT_W'(3);
  assign is_final = idx_ext >= m_eff;
  assign gap      = m_eff - idx_ext;
  assign ca       = (idx_ext >= CNT_W'(6)) ? 2'd3 : 2'(idx_ext - CNT_W'(3));

  always_comb begin
    if (is_final) begin
      cb = 2'd0;
    end else if (gap >= CNT_W'(3)) begin
      cb = 2'd3;
    end else begin
      cb = 2'(gap);
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    case (tap_r[1:0])
      2'd0: mac_coord = tap_r[2] ? cur_y_r : cur_x_r;
      2'd1: mac_coord = tap_r[2] ? win_y_r[0] : win_x_r[0];
      2'd2: mac_coord = tap_r[2] ? win_y_r[1] : win_x_r[1];
      default: mac_coord = tap_r[2] ? win_y_r[2] : win_x_r[2];
    endcase
  end

  assign mac_wgt      = W_TAB[cls_r][smp_r][tap_r[1:0]];
  assign mac_ctl.en   = (state_r == ST_MAC);
  assign mac_ctl.load = (tap_r[1:0] == 2'd0);

  bspl_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .coord  (mac_coord),
    .weight (mac_wgt),
    .result (mac_res)
  );

  always_comb begin
    state_nxt = state_r;
    commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (has_span) begin
            state_nxt = ST_MAC;
          end else begin
            commit = 1'b1;
          end
        end
      end
      ST_MAC: begin
        if (tap_r == 3'd7) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          if (smp_r != SMP_LAST) begin
            state_nxt = ST_MAC;
          end else if (final_r) begin
            state_nxt = ST_LAST;
          end else begin
            state_nxt = ST_IDLE;
            commit    = 1'b1;
          end
        end
      end
      ST_LAST: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          commit    = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign new_x = (state_r == ST_IDLE) ? $signed(in_tdata[15:0])  : cur_x_r;
  assign new_y = (state_r == ST_IDLE) ? $signed(in_tdata[31:16]) : cur_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_r       <= 3'd0;
      smp_r       <= '0;
      cls_r       <= '0;
      final_r     <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= 6'd4;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        win_x_r[k] <= '0;
        win_y_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cls_r   <= {ca, cb};
        final_r <= is_final;
        tap_r   <= 3'd0;
        smp_r   <= '0;
      end
      if (state_r == ST_MAC) begin
        tap_r <= tap_r + 3'd1;
      end
      if (state_r == ST_PUSH && out_free) begin
        smp_r <= smp_r + SMP_W'(1);
      end
      if (commit) begin
        win_x_r[2] <= win_x_r[1];
        win_y_r[2] <= win_y_r[1];
        win_x_r[1] <= win_x_r[0];
        win_y_r[1] <= win_y_r[0];
        win_x_r[0] <= new_x;
        win_y_r[0] <= new_y;
      end
      if (cfg_wr_en) begin
        cnt_r <= cfg_wr_data;
        idx_r <= '0;
      end else if (commit) begin
        idx_r <= (state_r == ST_LAST) ? '0 : idx_r + IDX_W'(1);
      end
      if ((state_r == ST_PUSH || state_r == ST_LAST) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x_r <= $signed(in_tdata[15:0]);
      cur_y_r <= $signed(in_tdata[31:16]);
    end
    if (state_r == ST_MAC && tap_r == 3'd4) begin
      res_x_r <= mac_res;
    end
    if (state_r == ST_PUSH && out_free) begin
      out_data_r <= {mac_res, res_x_r};
      out_last_r <= !final_r && (smp_r == SMP_LAST);
      out_done_r <= 1'b0;
    end else if (state_r == ST_LAST && out_free) begin
      out_data_r <= {cur_y_r, cur_x_r};
      out_last_r <= 1'b1;
      out_done_r <= 1'b1;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_done_r;

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("final curve point without end of run");

  a_last_needs_final: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LAST |-> final_r)
    else $error("final point emitted for a point that does not close the curve");

  a_next_sample: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUSH && out_free && smp_r != SMP_LAST |=> state_r == ST_MAC && tap_r == 3'd0)
    else $error("next sample did not restart the multiply-accumulate sequence");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_ext <= m_eff)
    else $error("point index beyond the last point of the curve");

endmodule

FILE: hw/rtl/bspl_mac.sv
module bspl_mac import bspl_pkg::*; (
  input  logic                      clk,
  input  mac_ctl_t                  ctl,
  input  logic signed [COORD_W-1:0] coord,
  input  logic [WGT_W-1:0]          weight,
  output logic signed [COORD_W-1:0] result
);

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(16384);
  localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] Q_MIN = -ACC_W'(32768);

  logic signed [COORD_W+WGT_W:0] prod;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       acc_nxt;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [ACC_W-1:0]       quo;

  assign prod = coord * $signed({1'b0, weight});

  always_comb begin
    if (ctl.load) begin
      acc_nxt = ACC_W'(prod);
    end else begin
      acc_nxt = acc_r + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign rnd = acc_r + HALF;
  assign quo = rnd >>> FRAC_SHIFT;

  always_comb begin
    if (quo > Q_MAX) begin
      result = COORD_W'(Q_MAX);
    end else if (quo < Q_MIN) begin
      result = COORD_W'(Q_MIN);
    end else begin
      result = COORD_W'(quo);
    end
  end

endmodule

FILE: bench/cubic_bspline_curve_sampler_test.sv
`timescale 1ns / 1ps

module cubic_bspline_curve_sampler_test;
  import bspl_pkg::SAMPLES_PER_SPAN;

  localparam int CURVE_MAX = 32;
  localparam longint UNIT = 12 * SAMPLES_PER_SPAN * SAMPLES_PER_SPAN * SAMPLES_PER_SPAN;
  localparam int POINT_TARGET = 470;
  localparam int IDLE_PCT = 36;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [3:0][15:0] quad_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic run_last;
    logic done;
  } curve_pt_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [31:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [31:0] out_tdata;
  logic out_tlast;
  logic [0:0] out_tuser;
  logic cfg_wr_en;
  logic [5:0] cfg_wr_data;

  logic [31:0] pending_points[$];
  curve_pt_t curve_expect_q[$];
  logic signed [15:0] win_x[3];
  logic signed [15:0] win_y[3];
  logic [5:0] count_reg;
  int next_index;
  int points_queued;
  int points_taken;
  int mismatches;
  int cycles;
  bit point_sent;
  bit calm;

  cubic_bspline_curve_sampler #(
    .MAX_POINTS(CURVE_MAX)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  function automatic longint knot_pos(longint j, longint last_idx);
    if (j <= 3) begin
      return 0;
    end
    if (j <= last_idx) begin
      return (j - 3) * SAMPLES_PER_SPAN;
    end
    return (last_idx - 2) * SAMPLES_PER_SPAN;
  endfunction

  function automatic quad_t blend_weights(longint span, longint smp, longint last_idx);
    longint basis[7];
    longint ts;
    longint j;
    longint lo;
    longint hi;
    longint width_l;
    longint width_r;
    longint part_l;
    longint part_r;
    longint v;
    quad_t wq;
    ts = SAMPLES_PER_SPAN * (span - 3) + smp;
    for (int o = 0; o < 7; o++) begin
      lo = knot_pos(span - 3 + o, last_idx);
      hi = knot_pos(span - 2 + o, last_idx);
      basis[o] = (lo < hi && lo <= ts && ts < hi) ? UNIT : 0;
    end
    for (int deg = 2; deg <= 4; deg++) begin
      for (int o = 0; o <= 7 - deg; o++) begin
        j = span - 3 + o;
        width_l = knot_pos(j + deg - 1, last_idx) - knot_pos(j, last_idx);
        width_r = knot_pos(j + deg, last_idx) - knot_pos(j + 1, last_idx);
        part_l = 0;
        part_r = 0;
        if (width_l > 0) begin
          part_l = (ts - knot_pos(j, last_idx)) * basis[o] / width_l;
        end
        if (width_r > 0) begin
          part_r = (knot_pos(j + deg, last_idx) - ts) * basis[o + 1] / width_r;
        end
        basis[o] = part_l + part_r;
      end
    end
    for (int o = 0; o < 4; o++) begin
      v = basis[3 - o];
      if (v < 0) begin
        v = 0;
      end
      wq[o] = 16'((v * 32768 + UNIT / 2) / UNIT);
    end
    return wq;
  endfunction

  function automatic logic signed [15:0] round_q15(longint acc);
    longint q;
    q = (acc + 16384) >>> 15;
    if (q > 32767) begin
      q = 32767;
    end
    if (q < -32768) begin
      q = -32768;
    end
    return 16'(q);
  endfunction

  function automatic logic [15:0] rand_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      case ($urandom_range(3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    if (pick < 30) begin
      return 16'($signed($urandom_range(4095)) - 2048);
    end
    return 16'($urandom);
  endfunction

  task automatic check_field(input string label, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_point(input logic [15:0] x, input logic [15:0] y);
    pending_points.push_back({y, x});
    points_queued++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (points_taken != points_queued || curve_expect_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic settle(input int n);
    repeat (n) @(negedge clk);
  endtask

  task automatic write_point_count(input logic [5:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    count_reg = val;
    next_index = 0;
  endtask

  always @(negedge clk) begin : feed
    logic nv;
    logic [31:0] nd;
    nv = in_tvalid;
    nd = in_tdata;
    if (point_sent) begin
      nv = 1'b0;
      point_sent = 1'b0;
    end
    if (rst_n && !nv && pending_points.size() > 0 &&
        (calm || $urandom_range(99) >= IDLE_PCT)) begin
      nd = pending_points.pop_front();
      nv = 1'b1;
    end
    in_tvalid <= nv;
    in_tdata <= nd;
    out_tready <= rst_n && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : watch
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    int n_eff;
    int last_idx;
    int span;
    bit at_end;
    quad_t wq;
    curve_pt_t pt;
    curve_pt_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        cx = in_tdata[15:0];
        cy = in_tdata[31:16];
        n_eff = (count_reg < 4) ? 4 : ((count_reg > CURVE_MAX) ? CURVE_MAX : int'(count_reg));
        last_idx = n_eff - 1;
        span = next_index;
        at_end = (span >= last_idx);
        if (span >= 3) begin
          if (span > last_idx) begin
            span = last_idx;
          end
          for (int s = 0; s < SAMPLES_PER_SPAN; s++) begin
            wq = blend_weights(span, s, last_idx);
            pt.x = round_q15(longint'(cx) * longint'(wq[0]) + longint'(win_x[0]) * longint'(wq[1])
                             + longint'(win_x[1]) * longint'(wq[2])
                             + longint'(win_x[2]) * longint'(wq[3]));
            pt.y = round_q15(longint'(cy) * longint'(wq[0]) + longint'(win_y[0]) * longint'(wq[1])
                             + longint'(win_y[1]) * longint'(wq[2])
                             + longint'(win_y[2]) * longint'(wq[3]));
            pt.run_last = !at_end && (s == SAMPLES_PER_SPAN - 1);
            pt.done = 1'b0;
            curve_expect_q.push_back(pt);
          end
        end
        if (at_end) begin
          pt.x = cx;
          pt.y = cy;
          pt.run_last = 1'b1;
          pt.done = 1'b1;
          curve_expect_q.push_back(pt);
          next_index = 0;
        end else begin
          next_index++;
        end
        win_x[2] = win_x[1];
        win_y[2] = win_y[1];
        win_x[1] = win_x[0];
        win_y[1] = win_y[0];
        win_x[0] = cx;
        win_y[0] = cy;
        points_taken++;
        point_sent = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (curve_expect_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got x %0d y %0d", $time,
                   $signed(out_tdata[15:0]), $signed(out_tdata[31:16]));
          mismatches++;
        end else begin
          want = curve_expect_q.pop_front();
          check_field("curve_x", want.x, $signed(out_tdata[15:0]));
          check_field("curve_y", want.y, $signed(out_tdata[31:16]));
          check_field("run_last", want.run_last, out_tlast);
          check_field("curve_done", want.done, out_tuser[0]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [5:0] plan[10];
    int phase;
    int n_eff;
    int burst;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    count_reg = 6'd4;
    next_index = 0;
    points_queued = 0;
    points_taken = 0;
    mismatches = 0;
    cycles = 0;
    point_sent = 1'b0;
    calm = 1'b0;
    for (int k = 0; k < 3; k++) begin
      win_x[k] = '0;
      win_y[k] = '0;
    end
    plan = '{6'd32, 6'd63, 6'd33, 6'd6, 6'd1, 6'd2, 6'd7, 6'd17, 6'd4, 6'd5};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    repeat (4) queue_point(16'h7FFF, 16'h7FFF);
    repeat (4) queue_point(16'h8000, 16'h8000);
    queue_point(16'h7FFF, 16'h8000);
    queue_point(16'h8000, 16'h7FFF);
    queue_point(16'h7FFF, 16'h8000);
    queue_point(16'h8000, 16'h7FFF);
    wait_drained();
    settle(SETTLE_CYCLES);

    write_point_count(6'd0);
    @(posedge clk);
    queue_point(16'h0000, 16'hFFFF);
    queue_point(16'hFFFF, 16'h0000);
    queue_point(16'h0001, 16'h0400);
    queue_point(16'hFC00, 16'hFFFF);
    wait_drained();
    settle(SETTLE_CYCLES);

    write_point_count(6'd3);
    @(posedge clk);
    queue_point(16'h5555, 16'hAAAA);
    queue_point(16'hAAAA, 16'h5555);
    wait_drained();
    settle(SETTLE_CYCLES);

    write_point_count(6'd5);
    @(posedge clk);
    for (int k = 0; k < 5; k++) begin
      queue_point(rand_coord(), rand_coord());
    end
    wait_drained();
    settle(SETTLE_CYCLES);

    phase = 0;
    while (points_queued < POINT_TARGET) begin
      if (phase < 10) begin
        write_point_count(plan[phase]);
      end else begin
        write_point_count(6'($urandom_range(63)));
      end
      n_eff = (count_reg < 4) ? 4 : ((count_reg > CURVE_MAX) ? CURVE_MAX : int'(count_reg));
      burst = 2 * n_eff + $urandom_range(n_eff - 1);
      calm = (phase == 3);
      @(posedge clk);
      for (int k = 0; k < burst; k++) begin
        queue_point(rand_coord(), rand_coord());
      end
      wait_drained();
      calm = 1'b0;
      settle(SETTLE_CYCLES);
      phase++;
    end

    wait_drained();
    settle(100);
    if (curve_expect_q.size() != 0) begin
      $display("%0t: expected %0d more transactions, got none", $time, curve_expect_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
